>>> hdl/vdb_pkg.sv
// Package for the vertex dedup bucket table.
// Holds field widths, opcode and status codes and the match result type.
// No dependencies.
`default_nettype none

package vdb_pkg;

  localparam int POS_W    = 13;
  localparam int IN_ATTR_W = 16;
  localparam int VTX_W    = 17;
  localparam int STATUS_W = 3;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_HIT    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEAR  = 3'd4;

  typedef struct packed {
    logic             hit;
    logic [VTX_W-1:0] vidx;
  } vdb_match_t;

endpackage

`default_nettype wire

>>> hdl/vdb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Width and depth are parameters; no dependencies.
`default_nettype none

module vdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/vdb_match.sv
// Bucket row compare: matches all ways in parallel, picks the first hit and
// builds the row with the new entry appended. Depends on vdb_pkg.
`default_nettype none

module vdb_match #(
  parameter int WAYS   = 20,
  parameter int ATTR_W = 16,
  parameter int FILL_W = 5
) (
  input  wire logic [WAYS*(2*ATTR_W+vdb_pkg::VTX_W)-1:0] row,
  input  wire logic [FILL_W-1:0]                        fill,
  input  wire logic [ATTR_W-1:0]                        tex,
  input  wire logic [ATTR_W-1:0]                        nrm,
  input  wire logic [vdb_pkg::VTX_W-1:0]                new_vidx,
  output vdb_pkg::vdb_match_t                           match,
  output logic      [WAYS*(2*ATTR_W+vdb_pkg::VTX_W)-1:0] row_next
);
  import vdb_pkg::*;

  localparam int ENT_W = 2*ATTR_W + VTX_W;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [WAYS-1:0]  ok;
  logic [WAY_W-1:0] slot;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      logic [ATTR_W-1:0] e_tex;
      logic [ATTR_W-1:0] e_nrm;
      logic              live;
      e_tex = row[w*ENT_W +: ATTR_W];
      e_nrm = row[w*ENT_W + ATTR_W +: ATTR_W];
      live  = (w < int'(fill));
      if (tex != '0) begin
        ok[w] = live && (e_tex == tex) && ((nrm == '0) || (e_nrm == nrm));
      end else if (nrm != '0) begin
        ok[w] = live && (e_nrm == nrm);
      end else begin
        ok[w] = live;
      end
    end
  end

  // take the lowest matching way
  always_comb begin
    match.hit  = 1'b0;
    match.vidx = '0;
    for (int w = WAYS-1; w >= 0; w--) begin
      if (ok[w]) begin
        match.hit  = 1'b1;
        match.vidx = row[w*ENT_W + 2*ATTR_W +: VTX_W];
      end
    end
  end

  assign slot = fill[WAY_W-1:0];

  always_comb begin
    row_next = row;
    row_next[slot*ENT_W +: ENT_W] = {new_vidx, nrm, tex};
  end

endmodule

`default_nettype wire

>>> hdl/vertex_dedup_bucket_table.sv
// Vertex dedup bucket table, top level: request handling, fill and row
// memories, clearing pass. Depends on vdb_pkg, vdb_ram and vdb_match.
//
//  channel  dir  tdata (low bit up)                   tuser
//  s_*      in   pos_index, tex_index, normal_index    opcode
//  m_*      out  vertex_index                          status
//
// A lookup or insert reads the fill count and bucket row from their memories
// when accepted, then compares all ways and writes back in the lookup state.
// A clear goes through the same lookup state, then a pass over every fill memory
// entry during which no request is taken; the same pass runs after reset.
// An item in the lookup state waits there while the result register is full.
`default_nettype none

module vertex_dedup_bucket_table #(
  parameter int POSITIONS       = 4096,
  parameter int BUCKET_WAYS     = 20,
  parameter int ATTR_INDEX_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // pos_index[12:0], tex_index[28:13], normal_index[44:29]
  input  wire logic [0:0]  s_tuser,  // opcode[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // vertex_index[16:0]
  output logic [2:0]       m_tuser   // status[2:0]
);
  import vdb_pkg::*;

  localparam int ADDR_W = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int FILL_W = $clog2(BUCKET_WAYS + 1);
  localparam int ENT_W  = 2*ATTR_INDEX_BITS + VTX_W;
  localparam int ROW_W  = BUCKET_WAYS * ENT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;

  logic [1:0] state, state_next;
  logic [ADDR_W-1:0] sweep_cnt;

  // latched request
  logic                       lk_op;
  logic                       lk_bad;
  logic [ADDR_W-1:0]          lk_addr;
  logic [ATTR_INDEX_BITS-1:0] lk_tex;
  logic [ATTR_INDEX_BITS-1:0] lk_nrm;

  logic [VTX_W-1:0] next_vertex, next_vertex_next;

  logic [POS_W-1:0]     in_pos;
  logic [31:0]          in_tex32, in_nrm32, in_b32;
  logic                 in_bad;
  logic                 accept;
  logic                 out_free;

  logic                 fill_we;
  logic [ADDR_W-1:0]    fill_waddr;
  logic [FILL_W-1:0]    fill_wdata;
  logic [FILL_W-1:0]    fill_rdata;
  logic                 ent_we;
  logic [ROW_W-1:0]     row_rdata;
  logic [ROW_W-1:0]     row_next;
  vdb_match_t           match;

  logic                 res_load;
  logic [VTX_W-1:0]     res_vidx;
  logic [STATUS_W-1:0]  res_status;
  logic                 look_fill_we;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign in_pos   = s_tdata[12:0];
  assign in_tex32 = {16'd0, s_tdata[28:13]};
  assign in_nrm32 = {16'd0, s_tdata[44:29]};
  assign in_b32   = 32'(in_pos) - 32'd1;
  assign in_bad   = (in_pos == '0) || (32'(in_pos) > POSITIONS);

  always_ff @(posedge clk) begin
    if (accept) begin
      lk_op   <= s_tuser[0];
      lk_bad  <= in_bad;
      lk_addr <= in_b32[ADDR_W-1:0];
      lk_tex  <= in_tex32[ATTR_INDEX_BITS-1:0];
      lk_nrm  <= in_nrm32[ATTR_INDEX_BITS-1:0];
    end
  end

  vdb_ram #(.WIDTH(FILL_W), .DEPTH(POSITIONS)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (accept),
    .raddr (in_b32[ADDR_W-1:0]),
    .rdata (fill_rdata)
  );

  vdb_ram #(.WIDTH(ROW_W), .DEPTH(POSITIONS)) u_row_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (lk_addr),
    .wdata (row_next),
    .re    (accept),
    .raddr (in_b32[ADDR_W-1:0]),
    .rdata (row_rdata)
  );

  vdb_match #(.WAYS(BUCKET_WAYS), .ATTR_W(ATTR_INDEX_BITS), .FILL_W(FILL_W)) u_match (
    .row      (row_rdata),
    .fill     (fill_rdata),
    .tex      (lk_tex),
    .nrm      (lk_nrm),
    .new_vidx (next_vertex),
    .match    (match),
    .row_next (row_next)
  );

  always_comb begin
    state_next       = state;
    next_vertex_next = next_vertex;
    res_load         = 1'b0;
    res_vidx         = '0;
    res_status       = ST_HIT;
    look_fill_we     = 1'b0;
    ent_we           = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          priority if (lk_op == OP_CLEAR) begin
            res_vidx         = next_vertex;
            res_status       = ST_CLEAR;
            next_vertex_next = '0;
            state_next       = S_SWEEP;
          end else if (lk_bad) begin
            res_status = ST_BADPOS;
          end else if (match.hit) begin
            res_vidx = match.vidx;
          end else begin
            res_vidx         = next_vertex;
            next_vertex_next = next_vertex + 1'b1;
            if (32'(fill_rdata) < BUCKET_WAYS) begin
              res_status   = ST_NEW;
              look_fill_we = 1'b1;
              ent_we       = 1'b1;
            end else begin
              res_status = ST_FULL;
            end
          end
        end
      end
      S_SWEEP: begin
        if (32'(sweep_cnt) == POSITIONS - 1) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (state == S_SWEEP) begin
      fill_we    = 1'b1;
      fill_waddr = sweep_cnt;
      fill_wdata = '0;
    end else begin
      fill_we    = look_fill_we;
      fill_waddr = lk_addr;
      fill_wdata = fill_rdata + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_cnt   <= '0;
      next_vertex <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      next_vertex <= next_vertex_next;
      if (state == S_SWEEP) begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end else begin
        sweep_cnt <= '0;
      end
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tdata <= {7'd0, res_vidx};
      m_tuser <= res_status;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_look: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_LOOK)
    else $error("accepted request did not move to lookup");

  a_result_from_look: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_LOOK)
    else $error("result appeared outside lookup");

  a_store_has_room: assert property (@(posedge clk) disable iff (rst)
    ent_we |-> 32'(fill_rdata) < BUCKET_WAYS)
    else $error("entry stored into a full bucket");

  a_clear_resets_count: assert property (@(posedge clk) disable iff (rst)
    (res_load && res_status == ST_CLEAR) |=> next_vertex == '0 && state == S_SWEEP)
    else $error("clear did not reset vertex count");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && 32'(sweep_cnt) != POSITIONS - 1) |=> !accept)
    else $error("request taken during clearing pass");
`endif

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking bench for vertex_dedup_bucket_table: streams lookup and clear
// requests with random stalls and checks every result against a bucket-table
// predictor held in a small scoreboard class. Depends on vdb_pkg and the RTL.

module tb_top;
  import vdb_pkg::*;

  localparam int TABLE_POSITIONS = 4096;
  localparam int TABLE_WAYS      = 20;
  localparam int MESHES          = 6;
  localparam int MESH_REQUESTS   = 172;
  localparam int LONG_HOLD       = 300;

  // Bucket table predictor and store of expected results.
  class vertex_index_tracker;
    bit [4:0]           bucket_fill [TABLE_POSITIONS];
    bit [IN_ATTR_W-1:0] row_tex [TABLE_POSITIONS*TABLE_WAYS];
    bit [IN_ATTR_W-1:0] row_nrm [TABLE_POSITIONS*TABLE_WAYS];
    bit [VTX_W-1:0]     row_vtx [TABLE_POSITIONS*TABLE_WAYS];
    bit [VTX_W-1:0]     vertex_count;
    bit [VTX_W-1:0]     expected_vertex [$];
    bit [STATUS_W-1:0]  expected_status [$];
    int errors, n_hit, n_new, n_full, n_badpos, n_clear;

    function void predict_vertex(bit op, bit [POS_W-1:0] pos,
                                 bit [IN_ATTR_W-1:0] tex, bit [IN_ATTR_W-1:0] nrm);
      int base;
      int idx;
      bit found;
      bit ok;
      bit [VTX_W-1:0] hit_vtx;
      if (op == OP_CLEAR) begin
        expected_vertex.push_back(vertex_count);
        expected_status.push_back(ST_CLEAR);
        foreach (bucket_fill[i]) bucket_fill[i] = '0;
        vertex_count = '0;
        n_clear++;
        return;
      end
      if (pos == 0 || pos > TABLE_POSITIONS) begin
        expected_vertex.push_back('0);
        expected_status.push_back(ST_BADPOS);
        n_badpos++;
        return;
      end
      base = (pos - 1) * TABLE_WAYS;
      found = 1'b0;
      hit_vtx = '0;
      for (int w = 0; w < bucket_fill[pos-1] && !found; w++) begin
        idx = base + w;
        if (tex != 0)
          ok = (row_tex[idx] == tex) && (nrm == 0 || row_nrm[idx] == nrm);
        else if (nrm != 0)
          ok = (row_nrm[idx] == nrm);
        else
          ok = 1'b1;
        if (ok) begin
          found = 1'b1;
          hit_vtx = row_vtx[idx];
        end
      end
      if (found) begin
        expected_vertex.push_back(hit_vtx);
        expected_status.push_back(ST_HIT);
        n_hit++;
        return;
      end
      expected_vertex.push_back(vertex_count);
      if (bucket_fill[pos-1] < TABLE_WAYS) begin
        idx = base + bucket_fill[pos-1];
        row_tex[idx] = tex;
        row_nrm[idx] = nrm;
        row_vtx[idx] = vertex_count;
        bucket_fill[pos-1] = 5'(bucket_fill[pos-1] + 1);
        expected_status.push_back(ST_NEW);
        n_new++;
      end else begin
        // bucket full: number handed out but not remembered
        expected_status.push_back(ST_FULL);
        n_full++;
      end
      vertex_count = VTX_W'(vertex_count + 1);
    endfunction

    function void check_vertex(bit [VTX_W-1:0] vtx, bit [STATUS_W-1:0] st);
      bit [VTX_W-1:0]    want_vtx;
      bit [STATUS_W-1:0] want_st;
      if (expected_vertex.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, vertex %0d status %0d", $time, vtx, st);
        return;
      end
      want_vtx = expected_vertex.pop_front();
      want_st  = expected_status.pop_front();
      if (vtx != want_vtx) begin
        errors++;
        $display("%0t: vertex_index expected %0d actual %0d", $time, want_vtx, vtx);
      end
      if (st != want_st) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want_st, st);
      end
    endfunction

    function int pending();
      return expected_vertex.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // pos_index[12:0], tex_index[28:13], normal_index[44:29]
  logic [0:0]  s_tuser = '0;  // opcode[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;       // vertex_index[16:0]
  logic [2:0]  m_tuser;       // status[2:0]

  bit calm = 1'b0;
  bit burst = 1'b0;
  bit hold_off_request = 1'b0;
  int sent = 0;

  vertex_index_tracker tracker = new;

  vertex_dedup_bucket_table u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_request(input logic op, input logic [POS_W-1:0] pos,
                              input logic [IN_ATTR_W-1:0] tex,
                              input logic [IN_ATTR_W-1:0] nrm);
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, nrm, tex, pos};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    tracker.predict_vertex(op, pos, tex, nrm);
    sent++;
    if (!calm && !burst && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Mostly a small pool so that lookups hit; now and then absent or any value.
  function automatic logic [IN_ATTR_W-1:0] pick_attr();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 18) return IN_ATTR_W'($urandom_range(0, 65535));
    return IN_ATTR_W'($urandom_range(1, 5));
  endfunction

  // Result side: check accepted results, then choose ready for the next edge.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        tracker.check_vertex(m_tdata[VTX_W-1:0], m_tuser);
      if (hold_off_request) begin
        hold_left = LONG_HOLD;
        hold_off_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(1, 7) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [POS_W-1:0] pos;
    int base_pos;
    int span;
    int roll;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty clear, bad positions, match rules, clear with a count
    send_request(OP_CLEAR, '0, '0, '0);
    send_request(OP_LOOKUP, 13'd0, 16'd7, 16'd7);
    send_request(OP_LOOKUP, 13'd4097, 16'd1, 16'd1);
    send_request(OP_LOOKUP, 13'h1FFF, 16'hFFFF, 16'hFFFF);
    send_request(OP_LOOKUP, 13'd1, 16'd0, 16'd0);
    send_request(OP_LOOKUP, 13'd1, 16'd0, 16'd0);
    send_request(OP_LOOKUP, 13'd4096, 16'hFFFF, 16'hFFFF);
    send_request(OP_LOOKUP, 13'd4096, 16'hFFFF, 16'd0);
    send_request(OP_LOOKUP, 13'd4096, 16'd0, 16'hFFFF);
    send_request(OP_LOOKUP, 13'd4096, 16'hFFFF, 16'd1);
    send_request(OP_LOOKUP, 13'd4096, 16'd2, 16'hFFFF);
    send_request(OP_LOOKUP, 13'd4096, 16'd0, 16'd1);
    send_request(OP_LOOKUP, 13'd4096, 16'd2, 16'd0);
    send_request(OP_CLEAR, 13'h1FFF, 16'hFFFF, 16'hFFFF);

    // random meshes over a few neighbouring buckets, each closed by a clear
    for (int mesh = 0; mesh < MESHES; mesh++) begin
      base_pos = $urandom_range(1, TABLE_POSITIONS - 12);
      span = (mesh % 2 == 1) ? 4 : 12;
      if (mesh == MESHES - 1) calm = 1'b1;
      if (mesh == 2) begin
        // stall the result side and keep offering until the input backs up
        hold_off_request = 1'b1;
        burst = 1'b1;
      end
      for (int n = 0; n < MESH_REQUESTS; n++) begin
        if (mesh == 2 && n == 40) burst = 1'b0;
        if (mesh == 3 && n == MESH_REQUESTS / 2) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
          wait_drained();
        end
        roll = $urandom_range(0, 99);
        if (roll < 4)
          pos = POS_W'($urandom_range(0, 8191));
        else if (roll < 6)
          pos = (roll == 4) ? 13'd0 : POS_W'(TABLE_POSITIONS);
        else
          pos = POS_W'(base_pos + $urandom_range(0, span - 1));
        send_request(OP_LOOKUP, pos, pick_attr(), pick_attr());
      end
      send_request(OP_CLEAR, POS_W'($urandom_range(0, 8191)),
                   IN_ATTR_W'($urandom_range(0, 65535)),
                   IN_ATTR_W'($urandom_range(0, 65535)));
    end

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d requests: %0d hits, %0d stored, %0d over full buckets,",
             sent, tracker.n_hit, tracker.n_new, tracker.n_full);
    $display("%0d bad positions and %0d clears; %0d mismatches.",
             tracker.n_badpos, tracker.n_clear, tracker.errors);
    if (tracker.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
